@@ rtl/core/sog_pkg.sv @@
// Shared types and constants for the segment occlusion gain unit.
`default_nettype none
package sog_pkg;

	localparam logic [15:0] UNITY     = 16'h8000;
	localparam logic [5:0]  DIV_LAST  = 6'd33;
	localparam logic [5:0]  SQRT_LAST = 6'd16;
	localparam logic [33:0] SQRT_BIT0 = 34'h1_0000_0000;

	typedef enum logic [1:0] {
		ACT_SET    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} sog_action_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LEN,
		ST_LEN_CHK,
		ST_SLOT_RD,
		ST_SLOT_LD,
		ST_DOT,
		ST_DOT_CHK,
		ST_CROSS,
		ST_MAG,
		ST_SQ,
		ST_DIV_SET,
		ST_DIV,
		ST_INNER,
		ST_SQRT,
		ST_OUTER_CHK,
		ST_FADE_MUL,
		ST_FDIV,
		ST_FADD,
		ST_GAIN,
		ST_NEXT,
		ST_DONE
	} sog_state_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         slot;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] bx;
		logic signed [15:0] by;
		logic signed [15:0] bz;
		logic [15:0]        inner_radius;
		logic [15:0]        outer_radius;
		logic [15:0]        max_atten;
	} sog_item_t;

	typedef struct packed {
		logic [15:0] gain;
		logic        is_query;
	} sog_result_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic [15:0]        inner;
		logic [15:0]        outer;
		logic [15:0]        atten;
	} sog_entry_t;

	typedef struct packed {
		logic       set;
		logic       remove;
		logic [3:0] slot;
		sog_entry_t entry;
	} sog_tbl_wr_t;

	typedef struct packed {
		logic       valid;
		sog_entry_t entry;
	} sog_tbl_rd_t;

endpackage
`default_nettype wire

@@ rtl/core/segment_occlusion_gain_unit.sv @@
// Segment occlusion gain unit: top level with handshake and result register.
//
// Input channel item_valid/item_ready carries one sog_item_t word; output channel
// result_valid/result_ready carries one sog_result_t word, exactly one per item.
// A set or remove item updates the occluder table and yields gain 1.0
// through the DONE state and the output register. A query squares the segment
// length, then, unless that is zero, walks every table slot: an empty slot or an
// occluder that projects outside the segment is skipped, others are evaluated.
// The work falls on the single shared multiplier and the shared compare-subtract
// unit, which runs a 34-step divide, a 17-step square root and a 34-step fade
// divide for an occluder, the last two only where its distance calls for them.
// item_ready is high only while the sequencer is idle; one item is in work at
// a time. A finished result sits in an output register, so the next item is
// taken while it waits; if the receiver stalls and the register is still
// full, the sequencer holds its next result until the register frees up.
// Reset clears the sequencer, the output valid flag and all slot valid flags.
`default_nettype none
module segment_occlusion_gain_unit #(
	parameter int SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  sog_pkg::sog_item_t    item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sog_pkg::sog_result_t  result
);
	import sog_pkg::*;

	logic                     core_idle;
	logic                     start;
	logic                     core_res_valid;
	logic                     res_take;
	sog_result_t              core_res;
	sog_tbl_wr_t              tbl_wr;
	sog_tbl_rd_t              tbl_rd;
	logic [$clog2(SLOTS)-1:0] rd_addr;
	logic                     result_valid_q;
	sog_result_t              result_q;

	assign item_ready = core_idle;
	assign start      = item_valid && core_idle;
	assign res_take   = !result_valid_q || result_ready;

	sog_core #(.SLOTS(SLOTS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res_take  (res_take),
		.res       (core_res),
		.tbl_wr    (tbl_wr),
		.rd_addr   (rd_addr),
		.tbl_rd    (tbl_rd)
	);

	sog_table #(.SLOTS(SLOTS)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd      (tbl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (core_res_valid && res_take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && res_take) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule
`default_nettype wire

@@ rtl/core/sog_mul.sv @@
// Shared 18x18 signed multiplier with registered product.
`default_nettype none
module sog_mul (
	input  logic               clk,
	input  logic signed [17:0] a,
	input  logic signed [17:0] b,
	output logic signed [35:0] p
);
	logic signed [35:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule
`default_nettype wire

@@ rtl/core/sog_sub.sv @@
// Shared compare-and-subtract step for the divider and the square root.
`default_nettype none
module sog_sub (
	input  logic [34:0] x,
	input  logic [34:0] y,
	output logic [34:0] diff,
	output logic        ge
);
	assign diff = x - y;
	assign ge   = (x >= y);
endmodule
`default_nettype wire

@@ rtl/core/sog_table.sv @@
// Occluder table: entry memory with registered read and per-slot valid flags.
`default_nettype none
module sog_table #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sog_pkg::sog_tbl_wr_t       wr,
	input  logic [$clog2(SLOTS)-1:0]   rd_addr,
	output sog_pkg::sog_tbl_rd_t       rd
);
	import sog_pkg::*;

	localparam int SW = $clog2(SLOTS);

	sog_entry_t       mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	sog_entry_t       rd_entry_q;
	logic             rd_vld_q;
	logic             slot_ok;
	logic [SW-1:0]    wa;
	sog_entry_t       wentry;

	assign slot_ok = (32'(wr.slot) < 32'(SLOTS));
	assign wa      = SW'(wr.slot);

	always_comb begin
		wentry       = wr.entry;
		// attenuation above one saturates
		wentry.atten = (wr.entry.atten > UNITY) ? UNITY : wr.entry.atten;
	end

	always_ff @(posedge clk) begin
		if (wr.set && slot_ok) begin
			mem_q[wa] <= wentry;
		end
		rd_entry_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.set && slot_ok) begin
				vld_q[wa] <= 1'b1;
			end else if (wr.remove && slot_ok) begin
				vld_q[wa] <= 1'b0;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd = '{valid: rd_vld_q, entry: rd_entry_q};
endmodule
`default_nettype wire

@@ rtl/core/sog_core.sv @@
// Sequencer and datapath: walks the table for a query using the shared units.
`default_nettype none
module sog_core #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  sog_pkg::sog_item_t         item,
	output logic                       idle,
	output logic                       res_valid,
	input  logic                       res_take,
	output sog_pkg::sog_result_t       res,
	output sog_pkg::sog_tbl_wr_t       tbl_wr,
	output logic [$clog2(SLOTS)-1:0]   rd_addr,
	input  sog_pkg::sog_tbl_rd_t       tbl_rd
);
	import sog_pkg::*;

	localparam int SW = $clog2(SLOTS);

	sog_state_t         state_q, state_d;
	logic [5:0]         j_q;
	logic [1:0]         i_q;
	logic [SW-1:0]      k_q;
	logic signed [15:0] lx_q, ly_q, lz_q;
	logic signed [16:0] d0_q, d1_q, d2_q, p0_q, p1_q, p2_q;
	logic [15:0]        inner_q, outer_q, att_q, f_q, gain_q;
	logic               qry_q;
	logic [33:0]        len2_q, cm_q, rem_q, nsh_q, den_q, q_q, bit_q;
	logic signed [36:0] acc_q;
	logic [67:0]        c2_q;

	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mp;
	logic signed [36:0] mp_ext;
	logic [34:0]        sub_x, sub_y, sub_diff;
	logic               sub_ge;
	logic               step_last;
	logic [33:0]        acc_mag;
	logic signed [36:0] len_s;
	logic               inner_hit, beyond, fade;

	sog_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mp));
	sog_sub u_sub (.x(sub_x), .y(sub_y), .diff(sub_diff), .ge(sub_ge));

	assign mp_ext    = 37'(mp);
	assign acc_mag   = acc_q[36] ? 34'(-acc_q) : acc_q[33:0];
	assign len_s     = $signed({3'b000, len2_q});
	// d2 against inner^2, product of the inner squaring sits in mp
	assign inner_hit = (q_q <= {2'b00, mp[31:0]});
	assign beyond    = (q_q > {18'd0, outer_q});
	assign fade      = (outer_q > inner_q) && (q_q > {18'd0, inner_q});
	assign rd_addr   = k_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_d = (item.action == ACT_QUERY) ? ST_LEN : ST_DONE;
			ST_LEN:       if (step_last) state_d = ST_LEN_CHK;
			ST_LEN_CHK:   state_d = (acc_q == '0) ? ST_DONE : ST_SLOT_RD;
			ST_SLOT_RD:   state_d = ST_SLOT_LD;
			ST_SLOT_LD:   state_d = tbl_rd.valid ? ST_DOT : ST_NEXT;
			ST_DOT:       if (step_last) state_d = ST_DOT_CHK;
			ST_DOT_CHK:   state_d = (acc_q > 0 && acc_q < len_s) ? ST_CROSS : ST_NEXT;
			ST_CROSS:     if (step_last) state_d = ST_MAG;
			ST_MAG:       state_d = ST_SQ;
			ST_SQ:        if (step_last) state_d = (i_q == 2'd2) ? ST_DIV_SET : ST_CROSS;
			ST_DIV_SET:   state_d = ST_DIV;
			ST_DIV:       if (step_last) state_d = ST_INNER;
			ST_INNER:     if (step_last) state_d = inner_hit ? ST_GAIN : ST_SQRT;
			ST_SQRT:      if (step_last) state_d = ST_OUTER_CHK;
			ST_OUTER_CHK: begin
				if (beyond) state_d = ST_NEXT;
				else state_d = fade ? ST_FADE_MUL : ST_GAIN;
			end
			ST_FADE_MUL:  if (step_last) state_d = ST_FDIV;
			ST_FDIV:      if (step_last) state_d = ST_FADD;
			ST_FADD:      state_d = ST_GAIN;
			ST_GAIN:      if (step_last) state_d = ST_NEXT;
			ST_NEXT:      state_d = (k_q == SW'(SLOTS - 1)) ? ST_DONE : ST_SLOT_RD;
			ST_DONE:      if (res_take) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		sub_x     = '0;
		sub_y     = '0;
		step_last = 1'b0;
		unique case (state_q)
			ST_LEN: begin
				step_last = (j_q == 6'd3);
				unique case (j_q[1:0])
					2'd0:    begin mul_a = 18'(d0_q); mul_b = 18'(d0_q); end
					2'd1:    begin mul_a = 18'(d1_q); mul_b = 18'(d1_q); end
					default: begin mul_a = 18'(d2_q); mul_b = 18'(d2_q); end
				endcase
			end
			ST_DOT: begin
				step_last = (j_q == 6'd3);
				unique case (j_q[1:0])
					2'd0:    begin mul_a = 18'(p0_q); mul_b = 18'(d0_q); end
					2'd1:    begin mul_a = 18'(p1_q); mul_b = 18'(d1_q); end
					default: begin mul_a = 18'(p2_q); mul_b = 18'(d2_q); end
				endcase
			end
			ST_CROSS: begin
				// component i of P x D, first term added, second subtracted
				step_last = (j_q == 6'd2);
				unique case (i_q)
					2'd0: begin
						mul_a = (j_q == 6'd0) ? 18'(p1_q) : 18'(p2_q);
						mul_b = (j_q == 6'd0) ? 18'(d2_q) : 18'(d1_q);
					end
					2'd1: begin
						mul_a = (j_q == 6'd0) ? 18'(p2_q) : 18'(p0_q);
						mul_b = (j_q == 6'd0) ? 18'(d0_q) : 18'(d2_q);
					end
					default: begin
						mul_a = (j_q == 6'd0) ? 18'(p0_q) : 18'(p1_q);
						mul_b = (j_q == 6'd0) ? 18'(d1_q) : 18'(d0_q);
					end
				endcase
			end
			ST_SQ: begin
				// |c|^2 from 17-bit halves: hi*hi, hi*lo (doubled by shift), lo*lo
				step_last = (j_q == 6'd3);
				unique case (j_q[1:0])
					2'd0:    begin mul_a = 18'(cm_q[33:17]); mul_b = 18'(cm_q[33:17]); end
					2'd1:    begin mul_a = 18'(cm_q[33:17]); mul_b = 18'(cm_q[16:0]); end
					default: begin mul_a = 18'(cm_q[16:0]);  mul_b = 18'(cm_q[16:0]); end
				endcase
			end
			ST_DIV, ST_FDIV: begin
				step_last = (j_q == DIV_LAST);
				sub_x     = {rem_q, nsh_q[33]};
				sub_y     = {1'b0, den_q};
			end
			ST_INNER: begin
				step_last = (j_q == 6'd1);
				mul_a     = 18'(inner_q);
				mul_b     = 18'(inner_q);
			end
			ST_SQRT: begin
				step_last = (j_q == SQRT_LAST);
				sub_x     = {1'b0, rem_q};
				sub_y     = {1'b0, q_q + bit_q};
			end
			ST_FADE_MUL: begin
				step_last = (j_q == 6'd1);
				mul_a     = 18'(UNITY - att_q);
				mul_b     = 18'(q_q[16:0] - 17'(inner_q));
			end
			ST_GAIN: begin
				step_last = (j_q == 6'd1);
				mul_a     = 18'(gain_q);
				mul_b     = 18'(f_q);
			end
			default: ;
		endcase

		idle             = (state_q == ST_IDLE);
		res_valid        = (state_q == ST_DONE);
		res.gain         = gain_q;
		res.is_query     = qry_q;
		tbl_wr.set       = idle && start && (item.action == ACT_SET);
		tbl_wr.remove    = idle && start && (item.action == ACT_REMOVE);
		tbl_wr.slot      = item.slot;
		tbl_wr.entry.px    = item.ax;
		tbl_wr.entry.py    = item.ay;
		tbl_wr.entry.pz    = item.az;
		tbl_wr.entry.inner = item.inner_radius;
		tbl_wr.entry.outer = item.outer_radius;
		tbl_wr.entry.atten = item.max_atten;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= (state_d != state_q) ? 6'd0 : j_q + 6'd1;
			if (state_q == ST_DOT_CHK) begin
				i_q <= '0;
			end else if (state_q == ST_SQ && step_last) begin
				i_q <= i_q + 2'd1;
			end
			if (state_q == ST_LEN_CHK) begin
				k_q <= '0;
			end else if (state_q == ST_NEXT) begin
				k_q <= k_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					lx_q   <= item.bx;
					ly_q   <= item.by;
					lz_q   <= item.bz;
					d0_q   <= 17'(item.ax) - 17'(item.bx);
					d1_q   <= 17'(item.ay) - 17'(item.by);
					d2_q   <= 17'(item.az) - 17'(item.bz);
					gain_q <= UNITY;
					qry_q  <= (item.action == ACT_QUERY);
					acc_q  <= '0;
				end
			end
			ST_LEN, ST_DOT: begin
				if (j_q != 6'd0) acc_q <= acc_q + mp_ext;
			end
			ST_LEN_CHK: len2_q <= acc_q[33:0];
			ST_SLOT_LD: begin
				p0_q    <= 17'(tbl_rd.entry.px) - 17'(lx_q);
				p1_q    <= 17'(tbl_rd.entry.py) - 17'(ly_q);
				p2_q    <= 17'(tbl_rd.entry.pz) - 17'(lz_q);
				inner_q <= tbl_rd.entry.inner;
				outer_q <= tbl_rd.entry.outer;
				att_q   <= tbl_rd.entry.atten;
				acc_q   <= '0;
			end
			ST_DOT_CHK: begin
				acc_q <= '0;
				c2_q  <= '0;
			end
			ST_CROSS: begin
				if (j_q == 6'd1) acc_q <= acc_q + mp_ext;
				else if (j_q == 6'd2) acc_q <= acc_q - mp_ext;
			end
			ST_MAG: cm_q <= acc_mag;
			ST_SQ: begin
				acc_q <= '0;
				if (j_q == 6'd1) c2_q <= c2_q + {mp[33:0], 34'd0};
				else if (j_q == 6'd2) c2_q <= c2_q + {16'd0, mp[33:0], 18'd0};
				else if (j_q == 6'd3) c2_q <= c2_q + {34'd0, mp[33:0]};
			end
			ST_DIV_SET: begin
				// quotient fits 34 bits, so the top half is already below len2
				rem_q <= c2_q[67:34];
				nsh_q <= c2_q[33:0];
				den_q <= len2_q;
				q_q   <= '0;
			end
			ST_DIV, ST_FDIV: begin
				rem_q <= sub_ge ? sub_diff[33:0] : sub_x[33:0];
				q_q   <= {q_q[32:0], sub_ge};
				nsh_q <= {nsh_q[32:0], 1'b0};
			end
			ST_INNER: begin
				if (j_q == 6'd1) begin
					f_q   <= att_q;
					rem_q <= q_q;
					q_q   <= '0;
					bit_q <= SQRT_BIT0;
				end
			end
			ST_SQRT: begin
				if (sub_ge) begin
					rem_q <= sub_diff[33:0];
					q_q   <= (q_q >> 1) + bit_q;
				end else begin
					q_q   <= q_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_FADE_MUL: begin
				if (j_q == 6'd1) begin
					rem_q <= '0;
					nsh_q <= mp[33:0];
					den_q <= {18'd0, outer_q - inner_q};
					q_q   <= '0;
				end
			end
			ST_FADD: f_q <= att_q + q_q[15:0];
			ST_GAIN: begin
				if (j_q == 6'd1) gain_q <= mp[30:15];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/sog_chk.sv @@
// Port-level checker for the segment occlusion gain unit, bound to the top level.
`default_nettype none
module sog_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input sog_pkg::sog_result_t  result
);
	import sog_pkg::*;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.gain <= UNITY)
		else $error("gain above unity");

	a_nonquery_unity: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_query |-> result.gain == UNITY)
		else $error("set/remove word without unity gain");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after accepting a word");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result word changed");
endmodule

bind segment_occlusion_gain_unit sog_chk u_sog_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
